FILE: hdl/lldq_pkg.sv
// Shared types and codes for the linked-list deque node pool.
// Depends on nothing; used by every module of the block.
`default_nettype none

package lldq_pkg;

	// Operation codes carried on the op input
	typedef enum logic [1:0] {
		OP_PUSH_FRONT = 2'd0,
		OP_PUSH_BACK  = 2'd1,
		OP_POP_FRONT  = 2'd2,
		OP_POP_BACK   = 2'd3
	} op_t;

	// Result status codes
	typedef enum logic [1:0] {
		STAT_DONE  = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	// Node store port enables
	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} node_ctl_t;

	// Free pool commands: take allocates a node, give recycles one
	typedef struct packed {
		logic take;
		logic give;
	} pool_ctl_t;

endpackage

`default_nettype wire

FILE: hdl/lldq_node_store.sv
// Node pool memory: value plus previous/next links per node.
// One write and one registered read port. Depends on lldq_pkg.
`default_nettype none

module lldq_node_store #(
	parameter int NODES      = 256,
	parameter int VALUE_BITS = 64
) (
	input  wire                          clk,
	input  lldq_pkg::node_ctl_t          ctl,
	input  wire [$clog2(NODES)-1:0]      wr_addr,
	input  wire [VALUE_BITS-1:0]         wr_data,
	input  wire [$clog2(NODES+1)-1:0]    wr_prev,
	input  wire [$clog2(NODES+1)-1:0]    wr_next,
	input  wire [$clog2(NODES)-1:0]      rd_addr,
	output logic [VALUE_BITS-1:0]        rd_data,
	output logic [$clog2(NODES+1)-1:0]   rd_prev,
	output logic [$clog2(NODES+1)-1:0]   rd_next
);

	localparam int IW = $clog2(NODES + 1);
	localparam int EW = VALUE_BITS + 2 * IW;

	logic [EW-1:0] node_mem [NODES];
	logic [EW-1:0] rd_q;

	// Write port
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			node_mem[wr_addr] <= {wr_data, wr_prev, wr_next};
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_q <= node_mem[rd_addr];
		end
	end

	assign rd_data = rd_q[EW-1 -: VALUE_BITS];
	assign rd_prev = rd_q[2*IW-1 -: IW];
	assign rd_next = rd_q[IW-1:0];

endmodule

`default_nettype wire

FILE: hdl/lldq_free_pool.sv
// Node allocator: recycle stack memory of freed nodes and their kept values,
// plus the count of never-used nodes. Depends on lldq_pkg.
`default_nettype none

module lldq_free_pool #(
	parameter int NODES      = 256,
	parameter int VALUE_BITS = 64
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  lldq_pkg::pool_ctl_t          ctl,
	input  wire [$clog2(NODES)-1:0]      give_idx,
	input  wire [VALUE_BITS-1:0]         give_val,
	output logic [$clog2(NODES)-1:0]     alloc_idx,
	output logic                         pool_full,
	output logic                         depth_nz,
	output logic [VALUE_BITS-1:0]        top_val
);

	localparam int IW = $clog2(NODES + 1);
	localparam int AW = $clog2(NODES);
	localparam int EW = AW + VALUE_BITS;

	logic [EW-1:0] stack_mem [NODES];
	logic [EW-1:0] top_q;
	logic [IW-1:0] depth_q;
	logic [IW-1:0] fresh_q;
	logic [IW-1:0] below_top;

	assign depth_nz  = (depth_q != '0);
	assign pool_full = !depth_nz && (fresh_q == IW'(NODES));
	assign alloc_idx = depth_nz ? top_q[EW-1 -: AW] : fresh_q[AW-1:0];
	assign top_val   = top_q[VALUE_BITS-1:0];
	assign below_top = depth_q - IW'(2);

	// Depth and fresh counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
			fresh_q <= '0;
		end else if (ctl.give) begin
			depth_q <= depth_q + IW'(1);
		end else if (ctl.take) begin
			if (depth_nz) begin
				depth_q <= depth_q - IW'(1);
			end else begin
				fresh_q <= fresh_q + IW'(1);
			end
		end
	end

	// Stack writes
	always_ff @(posedge clk) begin
		if (ctl.give) begin
			stack_mem[depth_q[AW-1:0]] <= {give_idx, give_val};
		end
	end

	// Cached top entry: loaded with the given entry on a give, refilled from the entry below the top on a take
	always_ff @(posedge clk) begin
		if (ctl.give) begin
			top_q <= {give_idx, give_val};
		end else if (ctl.take && (depth_q >= IW'(2))) begin
			top_q <= stack_mem[below_top[AW-1:0]];
		end
	end

endmodule

`default_nettype wire

FILE: hdl/linked_list_deque_node_pool_core.sv
// Linked-list deque in a node pool. A push goes from request accept through
// LINK to DONE; a pop goes through LINK, then FETCH when the deque keeps a next
// element, to DONE; a pop on empty or push on full pool goes straight to DONE.
// The next request is taken in the cycle its predecessor's result is
// registered. The steps read a neighbour's links and then write them back.
// arst_n clears control state; node and stack memories are not cleared.
`default_nettype none

module linked_list_deque_node_pool_core #(
	parameter int NODES      = 256,
	parameter int VALUE_BITS = 64
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	output logic                         in_ready,
	input  wire [1:0]                    op,
	input  wire [63:0]                   push_value,
	output logic                         out_valid,
	input  wire                          out_ready,
	output logic [1:0]                   status,
	output logic [$clog2(NODES+1)-1:0]   element_total,
	output logic [63:0]                  front_value,
	output logic [63:0]                  back_value,
	output logic [63:0]                  recent_value,
	output logic                         recent_valid
);

	localparam int IW = $clog2(NODES + 1);
	localparam int AW = $clog2(NODES);
	localparam logic [IW-1:0] NULL_IDX = IW'(NODES);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LINK,
		ST_FETCH,
		ST_DONE
	} state_t;

	state_t                   state_q;
	logic [IW-1:0]            head_q;
	logic [IW-1:0]            tail_q;
	logic [IW-1:0]            count_q;
	logic [VALUE_BITS-1:0]    front_val_q;
	logic [VALUE_BITS-1:0]    back_val_q;
	logic [IW-1:0]            old_q;
	logic [AW-1:0]            new_q;
	logic                     push_q;
	logic                     side_front_q;
	lldq_pkg::status_t        status_q;

	lldq_pkg::op_t            op_in;
	logic                     in_push;
	logic                     in_front;
	logic [IW-1:0]            old_in;
	logic                     old_ok;
	logic [VALUE_BITS-1:0]    val_in;
	logic                     accept;
	logic                     out_free;
	logic                     do_push;
	logic                     do_pop;
	logic [IW-1:0]            nb_idx;

	lldq_pkg::node_ctl_t      node_ctl;
	logic [AW-1:0]            node_wr_addr;
	logic [VALUE_BITS-1:0]    node_wr_data;
	logic [IW-1:0]            node_wr_prev;
	logic [IW-1:0]            node_wr_next;
	logic [AW-1:0]            node_rd_addr;
	logic [VALUE_BITS-1:0]    node_rd_data;
	logic [IW-1:0]            node_rd_prev;
	logic [IW-1:0]            node_rd_next;

	lldq_pkg::pool_ctl_t      pool_ctl;
	logic [AW-1:0]            alloc_idx;
	logic                     pool_full;
	logic                     depth_nz;
	logic [VALUE_BITS-1:0]    top_val;

	// Request decode
	assign op_in    = lldq_pkg::op_t'(op);
	assign in_push  = (op_in == lldq_pkg::OP_PUSH_FRONT) || (op_in == lldq_pkg::OP_PUSH_BACK);
	assign in_front = (op_in == lldq_pkg::OP_PUSH_FRONT) || (op_in == lldq_pkg::OP_POP_FRONT);
	assign old_in   = in_front ? head_q : tail_q;
	assign old_ok   = (old_in != NULL_IDX);
	assign val_in   = push_value[VALUE_BITS-1:0];

	// Handshake: take a request when idle or while handing over a result
	assign out_free = !out_valid || out_ready;
	assign in_ready = (state_q == ST_IDLE) || ((state_q == ST_DONE) && out_free);
	assign accept   = in_valid && in_ready;
	assign do_push  = accept && in_push && !pool_full;
	assign do_pop   = accept && !in_push && old_ok;

	// Neighbour of the popped node, from the node read
	assign nb_idx = side_front_q ? node_rd_next : node_rd_prev;

	// Node memory access per state
	always_comb begin
		node_ctl     = '0;
		node_wr_addr = new_q;
		node_wr_data = node_rd_data;
		node_wr_prev = node_rd_prev;
		node_wr_next = node_rd_next;
		node_rd_addr = old_in[AW-1:0];
		if (do_push) begin
			// new node, and read of the old end node to relink it
			node_ctl.wr_en = 1'b1;
			node_ctl.rd_en = old_ok;
			node_wr_addr   = alloc_idx;
			node_wr_data   = val_in;
			node_wr_prev   = in_front ? NULL_IDX : tail_q;
			node_wr_next   = in_front ? head_q : NULL_IDX;
		end else if (do_pop) begin
			node_ctl.rd_en = 1'b1;
		end else if (state_q == ST_LINK) begin
			if (push_q) begin
				// point the old end node at the new one
				node_ctl.wr_en = (old_q != NULL_IDX);
				node_wr_addr   = old_q[AW-1:0];
				if (side_front_q) begin
					node_wr_prev = IW'(new_q);
				end else begin
					node_wr_next = IW'(new_q);
				end
			end else begin
				// fetch the node that becomes the new end
				node_ctl.rd_en = (nb_idx != NULL_IDX);
				node_rd_addr   = nb_idx[AW-1:0];
			end
		end else if (state_q == ST_FETCH) begin
			// cut the new end's link to the popped node
			node_ctl.wr_en = 1'b1;
			node_wr_addr   = old_q[AW-1:0];
			if (side_front_q) begin
				node_wr_prev = NULL_IDX;
			end else begin
				node_wr_next = NULL_IDX;
			end
		end
	end

	// Allocation and recycling
	always_comb begin
		pool_ctl.take = do_push;
		pool_ctl.give = do_pop;
	end

	lldq_node_store #(
		.NODES      (NODES),
		.VALUE_BITS (VALUE_BITS)
	) u_node_store (
		.clk     (clk),
		.ctl     (node_ctl),
		.wr_addr (node_wr_addr),
		.wr_data (node_wr_data),
		.wr_prev (node_wr_prev),
		.wr_next (node_wr_next),
		.rd_addr (node_rd_addr),
		.rd_data (node_rd_data),
		.rd_prev (node_rd_prev),
		.rd_next (node_rd_next)
	);

	lldq_free_pool #(
		.NODES      (NODES),
		.VALUE_BITS (VALUE_BITS)
	) u_free_pool (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (pool_ctl),
		.give_idx  (old_in[AW-1:0]),
		.give_val  (in_front ? front_val_q : back_val_q),
		.alloc_idx (alloc_idx),
		.pool_full (pool_full),
		.depth_nz  (depth_nz),
		.top_val   (top_val)
	);

	// Sequencer, deque registers and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			head_q        <= NULL_IDX;
			tail_q        <= NULL_IDX;
			count_q       <= '0;
			front_val_q   <= '0;
			back_val_q    <= '0;
			old_q         <= NULL_IDX;
			new_q         <= '0;
			push_q        <= 1'b0;
			side_front_q  <= 1'b0;
			status_q      <= lldq_pkg::STAT_DONE;
			out_valid     <= 1'b0;
			status        <= '0;
			element_total <= '0;
			front_value   <= '0;
			back_value    <= '0;
			recent_value  <= '0;
			recent_valid  <= 1'b0;
		end else begin
			// drop a taken result unless the next one replaces it
			if (out_valid && out_ready && (state_q != ST_DONE)) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE, ST_DONE: begin
					// hand over the finished result
					if ((state_q == ST_DONE) && out_free) begin
						out_valid     <= 1'b1;
						status        <= status_q;
						element_total <= count_q;
						front_value   <= (count_q != '0) ? 64'(front_val_q) : '0;
						back_value    <= (count_q != '0) ? 64'(back_val_q) : '0;
						recent_valid  <= depth_nz;
						recent_value  <= depth_nz ? 64'(top_val) : '0;
					end
					// start the next request
					if (accept) begin
						push_q       <= in_push;
						side_front_q <= in_front;
						old_q        <= old_in;
						new_q        <= alloc_idx;
						if (in_push) begin
							if (pool_full) begin
								status_q <= lldq_pkg::STAT_FULL;
								state_q  <= ST_DONE;
							end else begin
								status_q <= lldq_pkg::STAT_DONE;
								count_q  <= count_q + IW'(1);
								state_q  <= ST_LINK;
								if (in_front) begin
									head_q      <= IW'(alloc_idx);
									front_val_q <= val_in;
									if (!old_ok) begin
										tail_q     <= IW'(alloc_idx);
										back_val_q <= val_in;
									end
								end else begin
									tail_q     <= IW'(alloc_idx);
									back_val_q <= val_in;
									if (!old_ok) begin
										head_q      <= IW'(alloc_idx);
										front_val_q <= val_in;
									end
								end
							end
						end else begin
							if (!old_ok) begin
								status_q <= lldq_pkg::STAT_EMPTY;
								state_q  <= ST_DONE;
							end else begin
								status_q <= lldq_pkg::STAT_DONE;
								count_q  <= count_q - IW'(1);
								state_q  <= ST_LINK;
							end
						end
					end else if ((state_q == ST_DONE) && out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_LINK: begin
					if (push_q) begin
						state_q <= ST_DONE;
					end else begin
						// move the popped end to its neighbour
						old_q <= nb_idx;
						if (side_front_q) begin
							head_q <= nb_idx;
							if (nb_idx == NULL_IDX) begin
								tail_q <= NULL_IDX;
							end
						end else begin
							tail_q <= nb_idx;
							if (nb_idx == NULL_IDX) begin
								head_q <= NULL_IDX;
							end
						end
						state_q <= (nb_idx == NULL_IDX) ? ST_DONE : ST_FETCH;
					end
				end
				ST_FETCH: begin
					if (side_front_q) begin
						front_val_q <= node_rd_data;
					end else begin
						back_val_q <= node_rd_data;
					end
					state_q <= ST_DONE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Checks
	a_head_tail_null: assert property (@(posedge clk) disable iff (!arst_n)
		(head_q == NULL_IDX) == (tail_q == NULL_IDX))
		else $error("head and tail disagree on an empty deque");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> ((head_q == NULL_IDX) == (count_q == '0)))
		else $error("element count out of step with head pointer");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		do_push |=> (count_q == $past(count_q) + IW'(1)))
		else $error("accepted push did not grow the deque");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= IW'(NODES))
		else $error("element count beyond pool size");

endmodule

`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for linked_list_deque_node_pool_core: drives random and directed
// deque requests, predicts every result with a local pool model and checks them in order.
// Depends on hdl/lldq_pkg.sv and the core module, which needs the node store and free pool.
`timescale 1ns / 100ps

module tb;

	localparam int          NODES          = 256;
	localparam int          VALUE_BITS     = 64;
	localparam logic [8:0]  NULL_IDX       = 9'(NODES);
	localparam int          CLK_HALF       = 10;
	localparam int          WATCHDOG_LIMIT = 2000;
	localparam int          SETTLE_CYCLES  = 8;

	typedef struct {
		lldq_pkg::status_t status;
		logic [8:0]        total;
		logic [63:0]       front;
		logic [63:0]       back;
		logic [63:0]       recent;
		logic              recent_ok;
	} deque_result_t;

	// DUT connections
	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  op;
	logic [63:0] push_value;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  status;
	logic [8:0]  element_total;
	logic [63:0] front_value;
	logic [63:0] back_value;
	logic [63:0] recent_value;
	logic        recent_valid;

	// Local copy of the node pool
	logic [63:0] pool_data  [NODES];
	logic [8:0]  pool_prev  [NODES];
	logic [8:0]  pool_next  [NODES];
	logic [7:0]  free_stack [NODES];
	logic [8:0]  pool_head;
	logic [8:0]  pool_tail;
	logic [8:0]  pool_count;
	logic [8:0]  free_depth;
	logic [8:0]  fresh_taken;

	deque_result_t pending_results[$];

	int n_sent;
	int n_results;
	int n_fail;
	int n_full_seen;
	int n_empty_seen;
	int src_gap_max;
	int sink_stall_max;
	int burst_left;

	linked_list_deque_node_pool_core #(
		.NODES      (NODES),
		.VALUE_BITS (VALUE_BITS)
	) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.op            (op),
		.push_value    (push_value),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.element_total (element_total),
		.front_value   (front_value),
		.back_value    (back_value),
		.recent_value  (recent_value),
		.recent_valid  (recent_valid)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_HALF) clk = ~clk;
	end

	// Apply one request to the pool copy and return the result it should give
	function automatic deque_result_t apply_request(lldq_pkg::op_t o, logic [63:0] v);
		deque_result_t r;
		logic [8:0]    n;
		logic [8:0]    old;
		logic [8:0]    top;
		r.status = lldq_pkg::STAT_DONE;
		case (o)
			lldq_pkg::OP_PUSH_FRONT, lldq_pkg::OP_PUSH_BACK: begin
				if (free_depth == 9'd0 && fresh_taken == 9'(NODES)) begin
					r.status = lldq_pkg::STAT_FULL;
				end else begin
					// recycled nodes first, then never-used ones in order
					if (free_depth != 9'd0) begin
						free_depth = free_depth - 9'd1;
						n = {1'b0, free_stack[free_depth[7:0]]};
					end else begin
						n = fresh_taken;
						fresh_taken = fresh_taken + 9'd1;
					end
					pool_data[n] = v;
					if (o == lldq_pkg::OP_PUSH_FRONT) begin
						old = pool_head;
						pool_prev[n] = NULL_IDX;
						pool_next[n] = old;
						if (old != NULL_IDX) pool_prev[old] = n;
						else pool_tail = n;
						pool_head = n;
					end else begin
						old = pool_tail;
						pool_next[n] = NULL_IDX;
						pool_prev[n] = old;
						if (old != NULL_IDX) pool_next[old] = n;
						else pool_head = n;
						pool_tail = n;
					end
					pool_count = pool_count + 9'd1;
				end
			end
			lldq_pkg::OP_POP_FRONT: begin
				old = pool_head;
				if (old == NULL_IDX) begin
					r.status = lldq_pkg::STAT_EMPTY;
				end else begin
					if (free_depth < 9'(NODES)) begin
						free_stack[free_depth[7:0]] = old[7:0];
						free_depth = free_depth + 9'd1;
					end
					pool_count = pool_count - 9'd1;
					pool_head = pool_next[old];
					if (pool_head != NULL_IDX) pool_prev[pool_head] = NULL_IDX;
					else pool_tail = NULL_IDX;
				end
			end
			default: begin
				old = pool_tail;
				if (old == NULL_IDX) begin
					r.status = lldq_pkg::STAT_EMPTY;
				end else begin
					if (free_depth < 9'(NODES)) begin
						free_stack[free_depth[7:0]] = old[7:0];
						free_depth = free_depth + 9'd1;
					end
					pool_count = pool_count - 9'd1;
					pool_tail = pool_prev[old];
					if (pool_tail != NULL_IDX) pool_next[pool_tail] = NULL_IDX;
					else pool_head = NULL_IDX;
				end
			end
		endcase
		r.total = pool_count;
		r.front = (pool_count != 9'd0) ? pool_data[pool_head] : 64'd0;
		r.back  = (pool_count != 9'd0) ? pool_data[pool_tail] : 64'd0;
		if (free_depth != 9'd0) begin
			top = free_depth - 9'd1;
			r.recent    = pool_data[free_stack[top[7:0]]];
			r.recent_ok = 1'b1;
		end else begin
			r.recent    = 64'd0;
			r.recent_ok = 1'b0;
		end
		return r;
	endfunction

	// Send one request; returns once it has been accepted (and any idle gap is over)
	task automatic send_request(lldq_pkg::op_t o, logic [63:0] v);
		in_valid   <= 1'b1;
		op         <= o;
		push_value <= v;
		do @(posedge clk); while (!in_ready);
		pending_results.insert(pending_results.size(), apply_request(o, v));
		n_sent++;
		if (burst_left > 0) burst_left--;
		if (burst_left == 0 && src_gap_max != 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, src_gap_max)) @(posedge clk);
			burst_left = $urandom_range(1, 20);
		end
	endtask

	// Hold the sender off until every outstanding result has been taken
	task automatic wait_results_drained();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		burst_left = $urandom_range(1, 20);
	endtask

	function automatic logic [63:0] rand_value();
		case ($urandom_range(0, 9))
			0:       return 64'd0;
			1:       return '1;
			default: return {$urandom(), $urandom()};
		endcase
	endfunction

	function automatic lldq_pkg::op_t rand_op(int push_pct);
		if ($urandom_range(0, 99) < push_pct)
			return $urandom_range(0, 1) ? lldq_pkg::OP_PUSH_BACK : lldq_pkg::OP_PUSH_FRONT;
		return $urandom_range(0, 1) ? lldq_pkg::OP_POP_BACK : lldq_pkg::OP_POP_FRONT;
	endfunction

	task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			n_fail++;
		end
	endtask

	// Result checker: each accepted result against the oldest prediction
	always @(posedge clk) begin : result_check
		deque_result_t want;
		if (arst_n && out_valid && out_ready) begin
			n_results++;
			if (pending_results.size() == 0) begin
				$error("result with no request outstanding");
				n_fail++;
			end else begin
				want = pending_results[0];
				pending_results.delete(0);
				if (want.status == lldq_pkg::STAT_FULL)  n_full_seen++;
				if (want.status == lldq_pkg::STAT_EMPTY) n_empty_seen++;
				check_field("status",        64'(want.status), 64'(status));
				check_field("element_total", 64'(want.total),  64'(element_total));
				check_field("front_value",   want.front,       front_value);
				check_field("back_value",    want.back,        back_value);
				check_field("recent_value",  want.recent,      recent_value);
				check_field("recent_valid",  64'(want.recent_ok), 64'(recent_valid));
			end
		end
	end

	// Back-pressure: random ready and stall runs in turn; none if sink_stall_max is 0
	always @(posedge clk) begin : sink_pattern
		int sink_left;
		bit sink_on;
		if (sink_stall_max == 0) begin
			out_ready <= 1'b1;
		end else begin
			if (sink_left <= 0) begin
				sink_on   = !sink_on;
				sink_left = sink_on ? $urandom_range(1, 16) : $urandom_range(1, sink_stall_max);
			end
			sink_left--;
			out_ready <= sink_on;
		end
	end

	// Watchdog: too long with no handshake on either side ends the run
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		wait (arst_n === 1'b1);
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
			else idle_cycles++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	// Pops on an empty deque from both ends
	task automatic test_empty_pops();
		send_request(lldq_pkg::OP_POP_FRONT, rand_value());
		send_request(lldq_pkg::OP_POP_BACK, rand_value());
	endtask

	// Value extremes at both ends, last-element pops and node reuse
	task automatic test_value_extremes();
		send_request(lldq_pkg::OP_PUSH_FRONT, 64'd0);
		send_request(lldq_pkg::OP_PUSH_BACK, '1);
		send_request(lldq_pkg::OP_PUSH_FRONT, 64'hAAAA_AAAA_AAAA_AAAA);
		send_request(lldq_pkg::OP_PUSH_BACK, 64'h5555_5555_5555_5555);
		send_request(lldq_pkg::OP_POP_FRONT, 64'd0);
		send_request(lldq_pkg::OP_POP_BACK, '1);
		send_request(lldq_pkg::OP_POP_FRONT, 64'd0);
		send_request(lldq_pkg::OP_POP_BACK, 64'd0);
		// deque now empty; the next push reuses the most recently recycled node
		send_request(lldq_pkg::OP_PUSH_BACK, 64'h0123_4567_89AB_CDEF);
		send_request(lldq_pkg::OP_POP_FRONT, '1);
		send_request(lldq_pkg::OP_PUSH_FRONT, 64'h8000_0000_0000_0001);
		send_request(lldq_pkg::OP_POP_BACK, 64'd0);
		send_request(lldq_pkg::OP_POP_FRONT, 64'd0);
	endtask

	// Fill every node, push against the full pool, then drain from random ends
	task automatic test_pool_full();
		while (pool_count < 9'(NODES)) send_request(rand_op(100), rand_value());
		send_request(lldq_pkg::OP_PUSH_FRONT, rand_value());
		send_request(lldq_pkg::OP_PUSH_BACK, rand_value());
		send_request(lldq_pkg::OP_POP_BACK, rand_value());
		send_request(lldq_pkg::OP_PUSH_FRONT, rand_value());
		send_request(lldq_pkg::OP_PUSH_BACK, rand_value());
		while (pool_count != 9'd0) send_request(rand_op(0), rand_value());
	endtask

	// One random phase; pops on an empty deque are not counted
	task automatic run_random_phase(int push_pct, int gap_max, int stall_max, int items);
		int             counted;
		lldq_pkg::op_t  o;
		src_gap_max    = gap_max;
		sink_stall_max = stall_max;
		counted        = 0;
		while (counted < items) begin
			o = rand_op(push_pct);
			if (o == lldq_pkg::OP_PUSH_FRONT || o == lldq_pkg::OP_PUSH_BACK ||
					pool_count != 9'd0) counted++;
			send_request(o, rand_value());
		end
	endtask

	// Random mix under varying idling, with a full pause part-way through
	task automatic test_random_mix();
		run_random_phase(60, 0, 0, 70);
		run_random_phase(75, 6, 4, 70);
		wait_results_drained();
		run_random_phase(30, 10, 12, 70);
		run_random_phase(50, 3, 20, 70);
	endtask

	initial begin
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		op             = lldq_pkg::OP_PUSH_FRONT;
		push_value     = 64'd0;
		out_ready      = 1'b0;
		n_sent         = 0;
		n_results      = 0;
		n_fail         = 0;
		n_full_seen    = 0;
		n_empty_seen   = 0;
		src_gap_max    = 4;
		sink_stall_max = 6;
		burst_left     = $urandom_range(1, 20);
		pool_head      = NULL_IDX;
		pool_tail      = NULL_IDX;
		pool_count     = 9'd0;
		free_depth     = 9'd0;
		fresh_taken    = 9'd0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_pops();
		test_value_extremes();
		wait_results_drained();
		src_gap_max    = 3;
		sink_stall_max = 8;
		test_pool_full();
		test_random_mix();

		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Covered %0d requests / %0d results: both push and pop ends, value extremes,",
			n_sent, n_results);
		$display("node reuse, %0d pops on empty and %0d pushes on a full pool.",
			n_empty_seen, n_full_seen);
		if (n_fail == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

FILE: linked_list_deque_node_pool_core.f
hdl/lldq_pkg.sv
hdl/lldq_node_store.sv
hdl/lldq_free_pool.sv
hdl/linked_list_deque_node_pool_core.sv
tb/tb.sv
